[hw/rtl/fsst_pkg.sv]
// Shared types and constants for the finger search sorted table.
// No dependencies; imported by fsst_key_ram and finger_search_sorted_table.
package fsst_pkg;

    localparam int KEY_W = 32;

    // Command codes carried on the input channel.
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_NONE   = 2'd3
    } t_command;

    // Search sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FINGER,
        ST_SCAN_LO,
        ST_SCAN_HI,
        ST_EMIT
    } t_state;

endpackage

[hw/rtl/finger_search_sorted_table.sv]
// Channel  | Signals                               | Direction
// input    | i_in_valid, o_in_ready, i_command,    | beat into the block
//          | i_key_value                           |
// output   | o_out_valid, i_out_ready, o_found     | beat out of the block (search only)
//
// Clear, append and unused commands are handled in idle. A search first
// reads the finger entry, then scans entries of the key memory read port
// (up to the table fill), and then loads the output register. Synchronous
// active-low reset empties the table and resets the finger; memory
// contents are not cleared. A waiting result does not stop the next beat
// being accepted; a finished search waits in its last state until the
// output register is free.
// Top level; depends on fsst_pkg and fsst_key_ram.
module finger_search_sorted_table #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_command,
    input  logic [fsst_pkg::KEY_W-1:0]   i_key_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_found
);
    import fsst_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [AW-1:0]      r_finger, n_finger;
    logic [CW-1:0]      r_pos, n_pos;
    logic [KEY_W-1:0]   r_key, n_key;
    logic               r_found, n_found;
    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;

    logic               wr_en;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [KEY_W-1:0]   rd_data;
    logic [CW-1:0]      pos_inc;
    logic [CW-1:0]      finger_inc;
    logic               rd_less;
    logic               rd_equal;

    // Key memory; writes happen only in idle and reads only during a search,
    // so the two ports never touch the same entry in one cycle.
    fsst_key_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_key_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Compares of the entry just read against the search key.
    assign rd_less    = $signed(rd_data) < $signed(r_key);
    assign rd_equal   = rd_data == r_key;
    assign pos_inc    = r_pos + 1'b1;
    assign finger_inc = CW'(r_finger) + 1'b1;

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_finger    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_finger    <= n_finger;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_pos       <= n_pos;
        r_key       <= n_key;
        r_found     <= n_found;
        r_out_found <= n_out_found;
    end

    // Next state and outputs of the search sequencer.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_finger    = r_finger;
        n_pos       = r_pos;
        n_key       = r_key;
        n_found     = r_found;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_found = r_out_found;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        rd_addr     = r_finger;
        o_in_ready  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    unique case (t_command'(i_command))
                        CMD_CLEAR: begin
                            n_count  = '0;
                            n_finger = '0;
                        end
                        CMD_APPEND: begin
                            if (r_count < CW'(TABLE_DEPTH)) begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        CMD_SEARCH: begin
                            n_key = i_key_value;
                            if (r_count == '0) begin
                                n_found = 1'b0;
                                n_state = ST_EMIT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_finger;
                                n_state = ST_FINGER;
                            end
                        end
                        CMD_NONE: begin
                        end
                    endcase
                end
            end
            ST_FINGER: begin
                // Decide the scan direction from the finger entry.
                if (rd_equal) begin
                    n_found = 1'b1;
                    n_state = ST_EMIT;
                end else if ($signed(r_key) < $signed(rd_data)) begin
                    n_pos   = '0;
                    rd_en   = 1'b1;
                    rd_addr = '0;
                    n_state = ST_SCAN_LO;
                end else begin
                    n_pos = finger_inc;
                    if (finger_inc >= r_count) begin
                        n_found = 1'b0;
                        n_state = ST_EMIT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = finger_inc[AW-1:0];
                        n_state = ST_SCAN_HI;
                    end
                end
            end
            ST_SCAN_LO: begin
                // Walk from the head, stopping at the finger.
                if (r_pos[AW-1:0] != r_finger && rd_less) begin
                    n_pos   = pos_inc;
                    rd_en   = 1'b1;
                    rd_addr = pos_inc[AW-1:0];
                end else begin
                    n_found = rd_equal;
                    if (rd_equal) begin
                        n_finger = r_pos[AW-1:0];
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN_HI: begin
                // Walk past the finger to the last entry, without wrapping.
                if (rd_less) begin
                    n_pos = pos_inc;
                    if (pos_inc >= r_count) begin
                        n_found = 1'b0;
                        n_state = ST_EMIT;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_inc[AW-1:0];
                    end
                end else begin
                    n_found = rd_equal;
                    if (rd_equal) begin
                        n_finger = r_pos[AW-1:0];
                    end
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_found;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out_found;

    // The fill count never exceeds the table depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // The finger always points inside a non-empty table.
    a_finger_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> (CW'(r_finger) < r_count))
        else $error("finger outside the filled part of the table");

    // The low scan never runs past the finger.
    a_scan_lo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_LO) |-> (r_pos <= CW'(r_finger)))
        else $error("low scan passed the finger");

    // The high scan stays beyond the finger and inside the table.
    a_scan_hi_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN_HI) |-> (r_pos < r_count && r_pos > CW'(r_finger)))
        else $error("high scan outside its range");

    // A scan or finger check is always preceded by a memory read.
    a_read_before_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINGER || r_state == ST_SCAN_LO || r_state == ST_SCAN_HI)
        |-> $past(rd_en))
        else $error("entry checked without a preceding read");

endmodule

[hw/rtl/fsst_key_ram.sv]
// Simple dual-port key memory: one write port, one registered read port.
// Depends on fsst_pkg for the key width.
module fsst_key_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [fsst_pkg::KEY_W-1:0]   i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [fsst_pkg::KEY_W-1:0]   o_rd_data
);
    import fsst_pkg::*;

    logic [KEY_W-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
